@@ rtl/core/sync_length_prefixed_deframer_unit_macros.svh @@
// assertion helpers for the deframer checker
`ifndef SYNC_LENGTH_PREFIXED_DEFRAMER_UNIT_MACROS_SVH
`define SYNC_LENGTH_PREFIXED_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SLPD_ASSERT_IMPLIES(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("deframer check failed");

// next-cycle implication, disabled while reset is high
`define SLPD_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("deframer check failed");

`endif

@@ rtl/core/slpd_pkg.sv @@
`default_nettype none
package slpd_pkg;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } slpd_req_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [1:0]  kind;
      logic [2:0]  error_code;
      logic [12:0] byte_index;
      logic        last;
   } slpd_rsp_type;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_COUNT,
      PH_SIZE_OK,
      PH_SIZE_BAD,
      PH_DATA
   } phase_type;

   typedef enum logic {
      CMD_DATA,
      CMD_ERROR
   } cmd_op_type;

   // one queue entry from front to back
   typedef struct packed {
      cmd_op_type  op;
      logic [7:0]  data_byte;
      logic [2:0]  error_code;
      logic [12:0] byte_index;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic [31:0] sync_word;
      logic [12:0] frame_limit;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   localparam logic       REQ_BYTE = 1'b0;

   localparam logic [1:0] KIND_ID      = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_COUNT_DIGIT = 3'd1;
   localparam logic [2:0] ERR_NOT_CANON   = 3'd2;
   localparam logic [2:0] ERR_TOO_LARGE   = 3'd3;
   localparam logic [2:0] ERR_TIMEOUT     = 3'd4;

   localparam logic [1:0] CSR_SYNC_WORD       = 2'd0;
   localparam logic [1:0] CSR_MAX_FRAME_BYTES = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS   = 2'd2;

   localparam logic [31:0] SYNC_WORD_RESET = 32'd0;
   localparam logic [12:0] MAX_FRAME_RESET = 13'd4500;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd300;

   localparam logic [7:0]  CHAR_ZERO = 8'h30;
   localparam logic [7:0]  CHAR_NINE = 8'h39;
   localparam logic [16:0] SIZE_CAP  = 17'd8191;
   localparam logic [12:0] ID_BYTES  = 13'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage
`default_nettype wire

@@ rtl/core/sync_length_prefixed_deframer_unit.sv @@
// Sync-word deframer: takes one byte or tick transaction per cycle and gives at most one
// result transaction per cycle; accepted transactions pass the command queue, then the
// output register; the front parser never holds off a byte, and req_stall rises only when
// the two-entry queue is full, which happens only after rsp_stall has held the output
// register. Each frame is a 4-byte sync word, one ASCII digit giving the size field
// length, a canonical decimal size, then 4 ID bytes and the payload, passed through with
// last on the final byte; errors give a single report and the parser hunts again.
`default_nettype none
module sync_length_prefixed_deframer_unit #(
   parameter int MAX_FRAME_LIMIT = 4500
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire slpd_pkg::slpd_req_type  req_payload,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      slpd_pkg::slpd_rsp_type  rsp_payload,
   input  wire logic                   csr_write_enable,
   input  wire logic [1:0]             csr_index,
   input  wire logic [31:0]            csr_write_data
);

   // hard ceiling on the frame size register
   localparam logic [12:0] LIMIT_CAP = 13'(MAX_FRAME_LIMIT);

   // configuration registers
   logic [31:0] sync_word_ff;
   logic [12:0] max_frame_ff;
   logic [15:0] timeout_ff;

   slpd_pkg::cfg_type          cfg;
   slpd_pkg::queue_status_type q_status;
   slpd_pkg::cmd_type          push_cmd;
   slpd_pkg::cmd_type          pop_cmd;
   logic                       accept;
   logic                       push;
   logic                       pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= slpd_pkg::SYNC_WORD_RESET;
         max_frame_ff <= slpd_pkg::MAX_FRAME_RESET;
         timeout_ff   <= slpd_pkg::TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            slpd_pkg::CSR_SYNC_WORD:       sync_word_ff <= csr_write_data;
            slpd_pkg::CSR_MAX_FRAME_BYTES: max_frame_ff <= csr_write_data[12:0];
            slpd_pkg::CSR_TIMEOUT_TICKS:   timeout_ff   <= csr_write_data[15:0];
            default: begin
               // writes past the register list are dropped
            end
         endcase
      end
   end

   always_comb begin
      cfg.sync_word     = sync_word_ff;
      // applied limit is the smaller of the register and the build ceiling
      cfg.frame_limit   = (max_frame_ff > LIMIT_CAP) ? LIMIT_CAP : max_frame_ff;
      cfg.timeout_ticks = timeout_ff;
   end

   // front side only holds off when the queue has no room
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // parser: hunts, reads the size field, numbers frame bytes
   slpd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cfg    (cfg),
      .push   (push),
      .cmd    (push_cmd)
   );

   // short queue that lets each side stall on its own
   slpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   // result formatting and the output register
   slpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_cmd       (pop_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

@@ rtl/core/slpd_front.sv @@
`default_nettype none
module slpd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire slpd_pkg::slpd_req_type req,
   input  wire slpd_pkg::cfg_type      cfg,
   output      logic                  push,
   output      slpd_pkg::cmd_type      cmd
);

   slpd_pkg::phase_type phase_ff, phase_in;
   logic [23:0] window_ff, window_in;
   logic [1:0]  fill_ff, fill_in;
   logic [3:0]  count_ff, count_in;
   logic [3:0]  seen_ff, seen_in;
   logic [12:0] accum_ff, accum_in;
   logic        ovf_ff, ovf_in;
   logic [12:0] frame_len_ff, frame_len_in;
   logic [12:0] bytes_ff, bytes_in;
   logic [15:0] idle_ff, idle_in;

   logic [31:0] word32;
   logic        is_digit;
   logic [3:0]  digit;
   logic [3:0]  seen_inc;
   logic [16:0] times_ten;
   logic [12:0] accum_next;
   logic        ovf_next;
   logic        bad_next;
   logic [15:0] idle_inc;
   logic [13:0] idx_plus;
   logic        last_flag;
   logic        hunt_clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= slpd_pkg::PH_HUNT;
         window_ff    <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         seen_ff      <= '0;
         accum_ff     <= '0;
         ovf_ff       <= 1'b0;
         frame_len_ff <= '0;
         bytes_ff     <= '0;
         idle_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         accum_ff     <= accum_in;
         ovf_ff       <= ovf_in;
         frame_len_ff <= frame_len_in;
         bytes_ff     <= bytes_in;
         idle_ff      <= idle_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      window_in    = window_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      accum_in     = accum_ff;
      ovf_in       = ovf_ff;
      frame_len_in = frame_len_ff;
      bytes_in     = bytes_ff;
      idle_in      = idle_ff;
      push         = 1'b0;
      cmd          = '0;
      cmd.op       = slpd_pkg::CMD_DATA;
      hunt_clear   = 1'b0;

      word32    = {window_ff, req.rx_byte};
      is_digit  = (req.rx_byte >= slpd_pkg::CHAR_ZERO) && (req.rx_byte <= slpd_pkg::CHAR_NINE);
      digit     = 4'(req.rx_byte - slpd_pkg::CHAR_ZERO);
      seen_inc  = seen_ff + 4'd1;
      times_ten = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1) + {13'b0, digit};
      accum_next = accum_ff;
      ovf_next   = ovf_ff;
      bad_next   = (phase_ff == slpd_pkg::PH_SIZE_BAD);
      idle_inc   = idle_ff + 16'd1;
      idx_plus   = {1'b0, bytes_ff} + 14'd1;
      last_flag  = (idx_plus >= {1'b0, frame_len_ff});

      if (accept) begin
         if (req.req_type != slpd_pkg::REQ_BYTE) begin
            // ticks only matter once a sync word has been seen
            if (phase_ff != slpd_pkg::PH_HUNT) begin
               idle_in = idle_inc;
               if ((idle_inc >= cfg.timeout_ticks) || (idle_inc == 16'd0)) begin
                  push           = 1'b1;
                  cmd.op         = slpd_pkg::CMD_ERROR;
                  cmd.error_code = slpd_pkg::ERR_TIMEOUT;
                  hunt_clear     = 1'b1;
                  phase_in       = slpd_pkg::PH_HUNT;
               end
            end
         end else begin
            idle_in = '0;
            unique case (phase_ff) inside
               slpd_pkg::PH_HUNT: begin
                  if ((fill_ff == 2'd3) && (word32 == cfg.sync_word)) begin
                     hunt_clear = 1'b1;
                     phase_in   = slpd_pkg::PH_COUNT;
                  end else begin
                     window_in = word32[23:0];
                     if (fill_ff != 2'd3) begin
                        fill_in = fill_ff + 2'd1;
                     end
                  end
               end
               slpd_pkg::PH_COUNT: begin
                  if (!is_digit) begin
                     push           = 1'b1;
                     cmd.op         = slpd_pkg::CMD_ERROR;
                     cmd.error_code = slpd_pkg::ERR_COUNT_DIGIT;
                     hunt_clear     = 1'b1;
                     phase_in       = slpd_pkg::PH_HUNT;
                  end else if (digit == 4'd0) begin
                     push           = 1'b1;
                     cmd.op         = slpd_pkg::CMD_ERROR;
                     cmd.error_code = slpd_pkg::ERR_NOT_CANON;
                     hunt_clear     = 1'b1;
                     phase_in       = slpd_pkg::PH_HUNT;
                  end else begin
                     count_in = digit;
                     seen_in  = '0;
                     accum_in = '0;
                     ovf_in   = 1'b0;
                     phase_in = slpd_pkg::PH_SIZE_OK;
                  end
               end
               slpd_pkg::PH_SIZE_OK, slpd_pkg::PH_SIZE_BAD: begin
                  seen_in = seen_inc;
                  if (!is_digit) begin
                     bad_next = 1'b1;
                  end else begin
                     // leading zero in a multi-digit field
                     if ((seen_inc == 4'd1) && (req.rx_byte == slpd_pkg::CHAR_ZERO) &&
                         (count_ff > 4'd1)) begin
                        bad_next = 1'b1;
                     end
                     if (!ovf_ff) begin
                        if (times_ten > slpd_pkg::SIZE_CAP) begin
                           ovf_next = 1'b1;
                        end else begin
                           accum_next = times_ten[12:0];
                        end
                     end
                  end
                  accum_in = accum_next;
                  ovf_in   = ovf_next;
                  phase_in = bad_next ? slpd_pkg::PH_SIZE_BAD : slpd_pkg::PH_SIZE_OK;
                  if (!(seen_inc < count_ff)) begin
                     if (bad_next) begin
                        push           = 1'b1;
                        cmd.op         = slpd_pkg::CMD_ERROR;
                        cmd.error_code = slpd_pkg::ERR_NOT_CANON;
                        hunt_clear     = 1'b1;
                        phase_in       = slpd_pkg::PH_HUNT;
                     end else if (ovf_next ||
                                  (({1'b0, accum_next} + {1'b0, slpd_pkg::ID_BYTES}) >
                                   {1'b0, cfg.frame_limit})) begin
                        push           = 1'b1;
                        cmd.op         = slpd_pkg::CMD_ERROR;
                        cmd.error_code = slpd_pkg::ERR_TOO_LARGE;
                        hunt_clear     = 1'b1;
                        phase_in       = slpd_pkg::PH_HUNT;
                     end else begin
                        frame_len_in = accum_next + slpd_pkg::ID_BYTES;
                        bytes_in     = '0;
                        phase_in     = slpd_pkg::PH_DATA;
                     end
                  end
               end
               slpd_pkg::PH_DATA: begin
                  push           = 1'b1;
                  cmd.op         = slpd_pkg::CMD_DATA;
                  cmd.data_byte  = req.rx_byte;
                  cmd.byte_index = bytes_ff;
                  cmd.last       = last_flag;
                  bytes_in       = idx_plus[12:0];
                  if (last_flag) begin
                     hunt_clear = 1'b1;
                     phase_in   = slpd_pkg::PH_HUNT;
                  end
               end
               default: begin
                  hunt_clear = 1'b1;
                  phase_in   = slpd_pkg::PH_HUNT;
               end
            endcase
         end
      end

      // back to an empty window and cleared counters
      if (hunt_clear) begin
         window_in    = '0;
         fill_in      = '0;
         count_in     = '0;
         seen_in      = '0;
         accum_in     = '0;
         ovf_in       = 1'b0;
         frame_len_in = '0;
         bytes_in     = '0;
         idle_in      = '0;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/slpd_queue.sv @@
`default_nettype none
module slpd_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire slpd_pkg::cmd_type           push_cmd,
   input  wire logic                       pop,
   output      slpd_pkg::cmd_type           pop_cmd,
   output      slpd_pkg::queue_status_type status
);

   slpd_pkg::cmd_type entries_ff [slpd_pkg::QUEUE_DEPTH];
   logic [slpd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [slpd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [slpd_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   always_comb begin
      status.full      = (count_ff == slpd_pkg::QUEUE_CNT_W'(slpd_pkg::QUEUE_DEPTH));
      status.not_empty = (count_ff != '0);
      do_push   = push && !status.full;
      do_pop    = pop && status.not_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == slpd_pkg::QUEUE_PTR_W'(slpd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + slpd_pkg::QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == slpd_pkg::QUEUE_PTR_W'(slpd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + slpd_pkg::QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + slpd_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - slpd_pkg::QUEUE_CNT_W'(1);
      end
      pop_cmd = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/slpd_back.sv @@
`default_nettype none
module slpd_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire slpd_pkg::queue_status_type q_status,
   input  wire slpd_pkg::cmd_type           q_cmd,
   output      logic                       pop,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      slpd_pkg::slpd_rsp_type      rsp_payload
);

   logic                   valid_ff, valid_in;
   slpd_pkg::slpd_rsp_type payload_ff, payload_in;

   always_comb begin
      pop      = q_status.not_empty && (!valid_ff || !rsp_stall);
      valid_in = pop ? 1'b1 : (valid_ff && rsp_stall);

      // turn a queue command into a result transaction
      payload_in = '0;
      if (q_cmd.op == slpd_pkg::CMD_ERROR) begin
         payload_in.kind       = slpd_pkg::KIND_ERROR;
         payload_in.error_code = q_cmd.error_code;
         payload_in.last       = 1'b1;
      end else begin
         payload_in.data_byte  = q_cmd.data_byte;
         payload_in.kind       = (q_cmd.byte_index < slpd_pkg::ID_BYTES) ?
                                 slpd_pkg::KIND_ID : slpd_pkg::KIND_PAYLOAD;
         payload_in.error_code = slpd_pkg::ERR_NONE;
         payload_in.byte_index = q_cmd.byte_index;
         payload_in.last       = q_cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         payload_ff <= payload_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule
`default_nettype wire

@@ rtl/core/slpd_checker.sv @@
`default_nettype none
`include "sync_length_prefixed_deframer_unit_macros.svh"
module slpd_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire slpd_pkg::slpd_rsp_type rsp_payload
);

   // a stalled result holds
   `SLPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // no result right after reset
   `SLPD_ASSERT_IMPLIES(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid)

   // error reports are final, carry a code and no data
   `SLPD_ASSERT_IMPLIES(a_error_shape, clock, reset, rsp_valid && (rsp_payload.kind == slpd_pkg::KIND_ERROR), rsp_payload.last && (rsp_payload.data_byte == 8'd0) && (rsp_payload.byte_index == 13'd0) && (rsp_payload.error_code != slpd_pkg::ERR_NONE))

   // data bytes carry no code, and id bytes are exactly the first four
   `SLPD_ASSERT_IMPLIES(a_data_shape, clock, reset, rsp_valid && (rsp_payload.kind != slpd_pkg::KIND_ERROR), (rsp_payload.error_code == slpd_pkg::ERR_NONE) && ((rsp_payload.byte_index < 13'd4) == (rsp_payload.kind == slpd_pkg::KIND_ID)))

endmodule

bind sync_length_prefixed_deframer_unit slpd_checker u_slpd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

   localparam int         FRAME_LIMIT_CAP  = 4500;
   localparam logic       REQ_TICK         = 1'b1;
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int         CYCLE_LIMIT      = 1000000;
   localparam int         DRAIN_CYCLES     = 8;
   localparam int         HOLD_OFF_CYCLES  = 300;
   localparam int         BURST_MAX        = 14;

   // how a generated frame is broken, if at all
   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_COUNT,
      FRAME_ZERO_COUNT,
      FRAME_LEADING_ZERO,
      FRAME_BAD_DIGIT,
      FRAME_TOO_LARGE,
      FRAME_TIMEOUT
   } frame_fault_type;

   // dut ports; the inputs are all known from time zero
   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   slpd_pkg::slpd_req_type req_payload      = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   slpd_pkg::slpd_rsp_type rsp_payload;
   logic                   csr_write_enable = 1'b0;
   logic [1:0]             csr_index        = '0;
   logic [31:0]            csr_write_data   = '0;

   // predicted deframer state and register copies
   slpd_pkg::phase_type rx_phase;
   logic [23:0]  rx_window;
   logic [1:0]   rx_window_fill;
   logic [3:0]   rx_size_len;
   logic [3:0]   rx_size_seen;
   logic [12:0]  rx_size_value;
   logic         rx_size_ovf;
   logic [12:0]  rx_frame_len;
   logic [12:0]  rx_frame_pos;
   logic [15:0]  rx_idle_ticks;
   logic [31:0]  cfg_sync_word;
   logic [12:0]  cfg_max_frame;
   logic [15:0]  cfg_timeout_ticks;

   // byte/tick transactions waiting for the driver, results waiting for the monitor
   slpd_pkg::slpd_req_type pending_items[$];
   slpd_pkg::slpd_rsp_type expected_outputs[$];

   // run control between the stimulus and the two handshake processes
   bit send_idle_enable = 1'b1;
   bit recv_idle_enable = 1'b1;
   bit hold_request     = 1'b0;

   int items_queued     = 0;
   int items_accepted   = 0;
   int results_checked  = 0;
   int frames_completed = 0;
   int mismatches       = 0;
   int cycle_count      = 0;
   int error_reports[0:7];

   sync_length_prefixed_deframer_unit #(
      .MAX_FRAME_LIMIT(FRAME_LIMIT_CAP)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // deframer prediction
   // ---------------------------------------------------------------

   // back to sync hunting with an empty window
   function automatic void restart_hunt;
      rx_phase       = slpd_pkg::PH_HUNT;
      rx_window      = '0;
      rx_window_fill = '0;
      rx_size_len    = '0;
      rx_size_seen   = '0;
      rx_size_value  = '0;
      rx_size_ovf    = 1'b0;
      rx_frame_len   = '0;
      rx_frame_pos   = '0;
      rx_idle_ticks  = '0;
   endfunction

   function automatic bit is_ascii_digit(input logic [7:0] b);
      return b >= slpd_pkg::CHAR_ZERO && b <= slpd_pkg::CHAR_NINE;
   endfunction

   // an error report always ends the frame and restarts the hunt
   function automatic void raise_error(output slpd_pkg::slpd_rsp_type res,
                                       input logic [2:0] code);
      restart_hunt();
      res            = '0;
      res.kind       = slpd_pkg::KIND_ERROR;
      res.error_code = code;
      res.last       = 1'b1;
   endfunction

   // advance the deframer by one transaction, returns 1 when a result is produced
   function automatic bit deframe_step(input slpd_pkg::slpd_req_type item,
                                       output slpd_pkg::slpd_rsp_type res);
      logic [7:0]  b;
      logic [31:0] word;
      logic [16:0] grown;
      int          limit;
      b   = item.rx_byte;
      res = '0;

      if (item.req_type == REQ_TICK) begin
         // ticks only count once a sync word was found
         if (rx_phase == slpd_pkg::PH_HUNT) return 1'b0;
         rx_idle_ticks = rx_idle_ticks + 16'd1;
         if (rx_idle_ticks >= cfg_timeout_ticks || rx_idle_ticks == 16'd0) begin
            raise_error(res, slpd_pkg::ERR_TIMEOUT);
            return 1'b1;
         end
         return 1'b0;
      end

      rx_idle_ticks = '0;
      case (rx_phase)
         slpd_pkg::PH_HUNT: begin
            word = {rx_window, b};
            if (rx_window_fill == 2'd3 && word == cfg_sync_word) begin
               restart_hunt();
               rx_phase = slpd_pkg::PH_COUNT;
            end else begin
               rx_window = word[23:0];
               if (rx_window_fill != 2'd3) rx_window_fill = rx_window_fill + 2'd1;
            end
            return 1'b0;
         end
         slpd_pkg::PH_COUNT: begin
            if (!is_ascii_digit(b)) begin
               raise_error(res, slpd_pkg::ERR_COUNT_DIGIT);
               return 1'b1;
            end
            rx_size_len = 4'(b - slpd_pkg::CHAR_ZERO);
            // a zero-length size field is never canonical
            if (rx_size_len == 4'd0) begin
               raise_error(res, slpd_pkg::ERR_NOT_CANON);
               return 1'b1;
            end
            rx_size_seen  = '0;
            rx_size_value = '0;
            rx_size_ovf   = 1'b0;
            rx_phase      = slpd_pkg::PH_SIZE_OK;
            return 1'b0;
         end
         slpd_pkg::PH_SIZE_OK, slpd_pkg::PH_SIZE_BAD: begin
            rx_size_seen = rx_size_seen + 4'd1;
            if (!is_ascii_digit(b)) begin
               rx_phase = slpd_pkg::PH_SIZE_BAD;
            end else begin
               // leading zero is bad unless the field is just "0"
               if (rx_size_seen == 4'd1 && b == slpd_pkg::CHAR_ZERO && rx_size_len > 4'd1)
                  rx_phase = slpd_pkg::PH_SIZE_BAD;
               if (!rx_size_ovf) begin
                  grown = rx_size_value * 17'd10 + 17'(b - slpd_pkg::CHAR_ZERO);
                  if (grown > slpd_pkg::SIZE_CAP) rx_size_ovf = 1'b1;
                  else rx_size_value = grown[12:0];
               end
            end
            // the whole field is consumed before any verdict
            if (rx_size_seen < rx_size_len) return 1'b0;
            if (rx_phase == slpd_pkg::PH_SIZE_BAD) begin
               raise_error(res, slpd_pkg::ERR_NOT_CANON);
               return 1'b1;
            end
            limit = (cfg_max_frame > FRAME_LIMIT_CAP) ? FRAME_LIMIT_CAP : int'(cfg_max_frame);
            if (rx_size_ovf || int'(rx_size_value) + 4 > limit) begin
               raise_error(res, slpd_pkg::ERR_TOO_LARGE);
               return 1'b1;
            end
            rx_frame_len = rx_size_value + slpd_pkg::ID_BYTES;
            rx_frame_pos = '0;
            rx_phase     = slpd_pkg::PH_DATA;
            return 1'b0;
         end
         slpd_pkg::PH_DATA: begin
            res.data_byte  = b;
            res.kind       = (rx_frame_pos < slpd_pkg::ID_BYTES) ?
                             slpd_pkg::KIND_ID : slpd_pkg::KIND_PAYLOAD;
            res.error_code = slpd_pkg::ERR_NONE;
            res.byte_index = rx_frame_pos;
            res.last       = (int'(rx_frame_pos) + 1 >= int'(rx_frame_len));
            rx_frame_pos   = rx_frame_pos + 13'd1;
            if (res.last) restart_hunt();
            return 1'b1;
         end
         default: begin
            restart_hunt();
            return 1'b0;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------

   function automatic void queue_byte(input logic [7:0] b);
      slpd_pkg::slpd_req_type item;
      item.req_type = slpd_pkg::REQ_BYTE;
      item.rx_byte  = b;
      pending_items = {pending_items, item};
      items_queued++;
   endfunction

   // the byte field of a tick is junk and must be ignored
   function automatic void queue_tick;
      slpd_pkg::slpd_req_type item;
      item.req_type = REQ_TICK;
      item.rx_byte  = 8'($urandom_range(0, 255));
      pending_items = {pending_items, item};
      items_queued++;
   endfunction

   function automatic logic [7:0] random_non_digit;
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0: b = "+";
         1: b = "-";
         default: b = 8'($urandom_range(0, 255));
      endcase
      if (is_ascii_digit(b)) b[7] = 1'b1;
      return b;
   endfunction

   // sync word, count digit, size field and body, broken as the fault says
   function automatic void queue_frame(input frame_fault_type fault, input int size);
      logic [7:0] digits[$];
      logic [7:0] body[$];
      int         eff_limit;
      int         value;
      int         cut;
      int         run;
      eff_limit = (cfg_max_frame > FRAME_LIMIT_CAP) ? FRAME_LIMIT_CAP : int'(cfg_max_frame);

      if (fault == FRAME_TOO_LARGE && $urandom_range(0, 2) == 0) begin
         // long digit strings push the value past the size cap
         repeat ($urandom_range(5, 9))
            digits = {digits, 8'(slpd_pkg::CHAR_ZERO + $urandom_range(0, 9))};
         digits[0] = 8'(slpd_pkg::CHAR_ZERO + $urandom_range(1, 9));
      end else begin
         value = size;
         if (fault == FRAME_TOO_LARGE)
            value = (eff_limit >= 4 ? eff_limit - 3 : 0) + $urandom_range(0, 20);
         do begin
            digits.push_front(8'(slpd_pkg::CHAR_ZERO + value % 10));
            value = value / 10;
         end while (value != 0);
      end
      if (fault == FRAME_LEADING_ZERO) digits.push_front(slpd_pkg::CHAR_ZERO);
      if (fault == FRAME_BAD_DIGIT)
         digits[$urandom_range(0, digits.size() - 1)] = random_non_digit();

      if (fault == FRAME_BAD_COUNT) body = {body, random_non_digit()};
      else if (fault == FRAME_ZERO_COUNT) body = {body, slpd_pkg::CHAR_ZERO};
      else body = {body, 8'(slpd_pkg::CHAR_ZERO + digits.size())};
      if (fault != FRAME_BAD_COUNT && fault != FRAME_ZERO_COUNT) begin
         for (int i = 0; i < digits.size(); i++) body = {body, digits[i]};
         if (fault == FRAME_GOOD || fault == FRAME_TIMEOUT)
            repeat (size + 4) body = {body, 8'($urandom_range(0, 255))};
         // a sync word inside the frame must not restart anything
         if (fault == FRAME_GOOD && $urandom_range(0, 3) == 0)
            for (int k = 0; k < 4; k++)
               body[1 + digits.size() + k] = cfg_sync_word[31 - 8 * k -: 8];
      end

      for (int k = 0; k < 4; k++) queue_byte(cfg_sync_word[31 - 8 * k -: 8]);
      cut = (fault == FRAME_TIMEOUT) ? $urandom_range(0, body.size() - 1) : -1;
      for (int i = 0; i < body.size(); i++) begin
         if (i == cut) begin
            // idle long enough to abort the frame in progress
            repeat (cfg_timeout_ticks == 16'd0 ? 1 : int'(cfg_timeout_ticks)) queue_tick();
            break;
         end
         queue_byte(body[i]);
         // short idle runs that stay under the timeout
         if (cfg_timeout_ticks >= 16'd2 && $urandom_range(0, 15) == 0) begin
            run = $urandom_range(1, cfg_timeout_ticks > 16'd4 ? 3 : int'(cfg_timeout_ticks) - 1);
            repeat (run) queue_tick();
         end
      end
   endfunction

   // hunting noise, then a mostly well-formed frame
   function automatic void queue_random_frame;
      int              pick;
      int              size;
      int              eff_limit;
      frame_fault_type fault;
      eff_limit = (cfg_max_frame > FRAME_LIMIT_CAP) ? FRAME_LIMIT_CAP : int'(cfg_max_frame);
      pick  = $urandom_range(0, 99);
      fault = pick < 60 ? FRAME_GOOD :
              pick < 67 ? FRAME_BAD_COUNT :
              pick < 72 ? FRAME_ZERO_COUNT :
              pick < 79 ? FRAME_LEADING_ZERO :
              pick < 86 ? FRAME_BAD_DIGIT :
              pick < 93 ? FRAME_TOO_LARGE : FRAME_TIMEOUT;
      if (fault == FRAME_TIMEOUT && cfg_timeout_ticks > 16'd40) fault = FRAME_GOOD;
      size = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 120);
      if (fault == FRAME_GOOD || fault == FRAME_TIMEOUT) begin
         if (eff_limit < 4) fault = FRAME_TOO_LARGE;
         else if (size > eff_limit - 4) size = eff_limit - 4;
      end
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 3) == 0) queue_tick();
         else queue_byte(8'($urandom_range(0, 255)));
      end
      queue_frame(fault, size);
   endfunction

   function automatic void queue_random_items(input int count);
      int start;
      start = items_queued;
      while (items_queued - start < count) queue_random_frame();
   endfunction

   // ---------------------------------------------------------------
   // register writes, only while the block is idle
   // ---------------------------------------------------------------

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         slpd_pkg::CSR_SYNC_WORD:       cfg_sync_word     = data;
         slpd_pkg::CSR_MAX_FRAME_BYTES: cfg_max_frame     = data[12:0];
         slpd_pkg::CSR_TIMEOUT_TICKS:   cfg_timeout_ticks = data[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // upper data bits are junk the block must drop
   task automatic configure(input logic [31:0] sync, input logic [12:0] max_bytes,
                            input logic [15:0] timeout);
      logic [31:0] junk;
      junk = $urandom;
      write_csr(slpd_pkg::CSR_SYNC_WORD, sync);
      write_csr(slpd_pkg::CSR_MAX_FRAME_BYTES, {junk[31:13], max_bytes});
      write_csr(slpd_pkg::CSR_TIMEOUT_TICKS, {junk[15:0], timeout});
   endtask

   // everything sent and checked, then a drain wait for in-flight work
   task automatic wait_drained;
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_outputs.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // request driver: offers queued transactions with random gaps
   // ---------------------------------------------------------------
   int gap_left = 0;

   always @(posedge clock) begin : req_driver
      bit                     sent;
      slpd_pkg::slpd_rsp_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         sent = req_valid && !req_stall;
         if (sent) begin
            items_accepted++;
            if (deframe_step(req_payload, predicted))
               expected_outputs = {expected_outputs, predicted};
         end
         // a stalled transaction stays put
         if (!req_valid || sent) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (send_idle_enable && pending_items.size() != 0 &&
                         $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, BURST_MAX) - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_payload <= pending_items.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // response side: random stall bursts and one long hold-off
   // ---------------------------------------------------------------
   int hold_left  = 0;
   int stall_left = 0;

   always @(posedge clock) begin : rsp_staller
      logic stall_next;
      if (hold_request) begin
         hold_left    = HOLD_OFF_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         stall_next = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         stall_next = 1'b1;
      end else if (recv_idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, BURST_MAX) - 1;
         stall_next = 1'b1;
      end else begin
         stall_next = 1'b0;
      end
      rsp_stall <= stall_next;
   end

   // ---------------------------------------------------------------
   // response monitor: each result against the oldest prediction
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      slpd_pkg::slpd_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result transaction, expected none, actual %h",
                     $time, rsp_payload);
         end else begin
            want = expected_outputs.pop_front();
            check_field("data_byte", 16'(want.data_byte), 16'(rsp_payload.data_byte));
            check_field("kind", 16'(want.kind), 16'(rsp_payload.kind));
            check_field("error_code", 16'(want.error_code), 16'(rsp_payload.error_code));
            check_field("byte_index", 16'(want.byte_index), 16'(rsp_payload.byte_index));
            check_field("last", 16'(want.last), 16'(rsp_payload.last));
            results_checked++;
            if (want.kind == slpd_pkg::KIND_ERROR) error_reports[want.error_code]++;
            else if (want.last) frames_completed++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sync_length_prefixed_deframer_unit test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin : stimulus
      foreach (error_reports[i]) error_reports[i] = 0;
      cfg_sync_word     = slpd_pkg::SYNC_WORD_RESET;
      cfg_max_frame     = slpd_pkg::MAX_FRAME_RESET;
      cfg_timeout_ticks = slpd_pkg::TIMEOUT_RESET;
      restart_hunt();

      // hold reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part on reset register values (all-zero sync word)
      queue_tick();                               // tick while hunting is ignored
      queue_byte(8'h00);
      queue_byte(8'h00);
      queue_tick();                               // partial window survives a tick
      queue_byte(8'h00);
      queue_byte(8'h00);
      queue_byte(8'(slpd_pkg::CHAR_ZERO + 1));    // one size digit
      queue_byte(slpd_pkg::CHAR_ZERO);            // size zero: id bytes only
      queue_byte(8'hFF);
      queue_byte(8'h00);
      queue_byte(8'hA5);
      queue_byte(8'h5A);
      repeat (4) queue_byte(8'h00);
      queue_byte("x");                            // count byte not a digit
      repeat (4) queue_byte(8'h00);
      queue_byte(slpd_pkg::CHAR_ZERO);            // zero digit count
      wait_drained();

      // all-ones sync, one idle tick aborts, writes to the spare index are dropped
      write_csr(CSR_UNUSED_INDEX, $urandom);
      configure(32'hFFFF_FFFF, 13'd4500, 16'd1);
      queue_random_items(25);
      wait_drained();

      // limit below the id bytes: every well-formed frame too large; first tick aborts
      configure($urandom, 13'd2, 16'd0);
      queue_random_items(20);
      wait_drained();

      // limit of exactly the id bytes
      configure($urandom, 13'd4, 16'd7);
      queue_random_items(15);
      wait_drained();

      // register above the cap, longest timeout, sizes just past the cap
      configure($urandom, 13'd8191, 16'd65535);
      queue_frame(FRAME_TOO_LARGE, 0);
      queue_frame(FRAME_TOO_LARGE, 0);
      queue_random_items(15);
      wait_drained();

      // backpressure: receiver holds off while the sender keeps offering
      configure($urandom, 13'($urandom_range(40, 300)), 16'($urandom_range(2, 20)));
      send_idle_enable = 1'b0;
      hold_request     = 1'b1;
      repeat (3) queue_frame(FRAME_GOOD, 12);
      wait_drained();
      send_idle_enable = 1'b1;

      // random settings with random frames
      repeat (3) begin
         configure($urandom, 13'($urandom_range(4, 600)), 16'($urandom_range(1, 30)));
         queue_random_items(35);
         wait_drained();
      end

      // final stretch at full rate on both sides
      send_idle_enable = 1'b0;
      recv_idle_enable = 1'b0;
      configure($urandom, 13'($urandom_range(4, 600)), 16'($urandom_range(1, 30)));
      queue_random_items(35);
      wait_drained();

      $display("run covered %0d byte and tick transactions, %0d result transactions, %0d frames",
               items_accepted, results_checked, frames_completed);
      $display("error reports: count %0d, canonical %0d, too large %0d, timeout %0d",
               error_reports[slpd_pkg::ERR_COUNT_DIGIT], error_reports[slpd_pkg::ERR_NOT_CANON],
               error_reports[slpd_pkg::ERR_TOO_LARGE], error_reports[slpd_pkg::ERR_TIMEOUT]);
      if (mismatches == 0 && expected_outputs.size() == 0) begin
         $display("sync_length_prefixed_deframer_unit test passed");
      end else begin
         $display("sync_length_prefixed_deframer_unit test failed");
      end
      $finish;
   end

endmodule
